[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check a property at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

[hw/rtl/nket_pkg.sv]
// ----------------------------------------------------------------------------
// nket_pkg
// Types and codes for the name keyed entry table.
// ----------------------------------------------------------------------------
package nket_pkg;

  // Command codes
  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_SEARCH = 3'd1;
  localparam logic [2:0] CMD_DELETE = 3'd2;
  localparam logic [2:0] CMD_LIST   = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  // Result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_EMPTY     = 2'd2;
  localparam logic [1:0] STAT_FULL      = 2'd3;

  typedef struct packed {
    logic        [2:0]  cmd;
    logic        [63:0] key_bytes_0_7;
    logic        [63:0] key_bytes_8_15;
    logic        [31:0] key_bytes_16_19;
    logic signed [31:0] phone_value;
  } in_item_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic        [63:0] out_bytes_0_7;
    logic        [63:0] out_bytes_8_15;
    logic        [31:0] out_bytes_16_19;
    logic signed [31:0] out_phone;
    logic               last_result;
  } out_item_t;

  // One stored table entry
  typedef struct packed {
    logic [63:0] name_low;
    logic [63:0] name_mid;
    logic [31:0] name_high;
    logic [31:0] phone;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_DEL_SHIFT,
    S_INS_SHIFT,
    S_INS_HEAD,
    S_LIST
  } tbl_state_t;

endpackage

[hw/rtl/name_keyed_entry_table.sv]
// Results are registered, appearing in the cycle after the step that makes them.
// Insert shifts entries down, oldest first, then writes the new one at the head;
// search walks from the newest entry to a match or the end; delete searches, then
// shifts older entries up; list gives one result per cycle. Clear, full and empty
// cases end without raising busy. Walks take one entry per cycle through the single
// read port; start is taken only when idle. Reset clears the count and control only.
// ----------------------------------------------------------------------------
// name_keyed_entry_table
// Bounded newest-first table of name/number entries in one synchronous memory,
// walked one entry per cycle for search, delete, list and insert shifting.
// ----------------------------------------------------------------------------
module name_keyed_entry_table
  import nket_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  entry_t mem [TABLE_DEPTH];

  tbl_state_t    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [2:0]    cmd_r, cmd_nxt;
  entry_t        key_r, key_nxt;
  entry_t        rd_data_r;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_r, out_nxt;

  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;

  logic   accept;
  logic   tbl_empty;
  logic   tbl_full;
  logic   key_hit;
  logic   idx_last;
  entry_t in_entry;
  out_item_t blank_out;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign tbl_empty = (count_r == '0);
  assign tbl_full  = (count_r == CW'(TABLE_DEPTH));
  assign idx_last  = ((CW'(idx_r) + CW'(1)) == count_r);
  assign key_hit   = (rd_data_r.name_low == key_r.name_low) &&
                     (rd_data_r.name_mid == key_r.name_mid) &&
                     (rd_data_r.name_high == key_r.name_high);

  assign in_entry.name_low  = in_item.key_bytes_0_7;
  assign in_entry.name_mid  = in_item.key_bytes_8_15;
  assign in_entry.name_high = in_item.key_bytes_16_19;
  assign in_entry.phone     = in_item.phone_value;

  always_comb begin
    blank_out             = '0;
    blank_out.last_result = 1'b1;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_item.cmd)
            CMD_INSERT: if (!tbl_full && !tbl_empty) state_nxt = S_INS_SHIFT;
            CMD_SEARCH: if (!tbl_empty) state_nxt = S_SEARCH;
            CMD_DELETE: if (!tbl_empty) state_nxt = S_SEARCH;
            CMD_LIST:   if (!tbl_empty) state_nxt = S_LIST;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_SEARCH: begin
        if (key_hit) begin
          if (cmd_r == CMD_DELETE && !idx_last) state_nxt = S_DEL_SHIFT;
          else state_nxt = S_IDLE;
        end else if (idx_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_DEL_SHIFT: if (idx_last) state_nxt = S_IDLE;
      S_INS_SHIFT: if (idx_r == '0) state_nxt = S_INS_HEAD;
      S_INS_HEAD:  state_nxt = S_IDLE;
      S_LIST:      if (idx_last) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // Memory access, counters and results
  always_comb begin
    rd_en         = 1'b0;
    rd_addr       = idx_r;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_data       = rd_data_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt = in_item.cmd;
          key_nxt = in_entry;
          case (in_item.cmd)
            CMD_INSERT: begin
              if (tbl_full) begin
                out_valid_nxt  = 1'b1;
                out_nxt        = blank_out;
                out_nxt.status = STAT_FULL;
              end else if (tbl_empty) begin
                wr_en          = 1'b1;
                wr_addr        = '0;
                wr_data        = in_entry;
                count_nxt      = count_r + CW'(1);
                out_valid_nxt  = 1'b1;
                out_nxt        = blank_out;
              end else begin
                // Start the shift from the oldest entry
                rd_en   = 1'b1;
                rd_addr = IW'(count_r - CW'(1));
                idx_nxt = IW'(count_r - CW'(1));
              end
            end
            CMD_SEARCH, CMD_DELETE, CMD_LIST: begin
              if (tbl_empty) begin
                out_valid_nxt  = 1'b1;
                out_nxt        = blank_out;
                out_nxt.status = (in_item.cmd == CMD_SEARCH) ? STAT_NOT_FOUND
                                                             : STAT_EMPTY;
              end else begin
                rd_en   = 1'b1;
                rd_addr = '0;
                idx_nxt = '0;
              end
            end
            CMD_CLEAR: begin
              count_nxt     = '0;
              out_valid_nxt = 1'b1;
              out_nxt       = blank_out;
            end
            default: begin
              out_valid_nxt = 1'b0;
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (key_hit) begin
          out_valid_nxt           = 1'b1;
          out_nxt.status          = STAT_OK;
          out_nxt.out_bytes_0_7   = rd_data_r.name_low;
          out_nxt.out_bytes_8_15  = rd_data_r.name_mid;
          out_nxt.out_bytes_16_19 = rd_data_r.name_high;
          out_nxt.out_phone       = rd_data_r.phone;
          out_nxt.last_result     = 1'b1;
          if (cmd_r == CMD_DELETE) begin
            if (idx_last) begin
              count_nxt = count_r - CW'(1);
            end else begin
              rd_en   = 1'b1;
              rd_addr = IW'(idx_r + 1'b1);
              idx_nxt = IW'(idx_r + 1'b1);
            end
          end
        end else if (idx_last) begin
          out_valid_nxt  = 1'b1;
          out_nxt        = blank_out;
          out_nxt.status = STAT_NOT_FOUND;
        end else begin
          rd_en   = 1'b1;
          rd_addr = IW'(idx_r + 1'b1);
          idx_nxt = IW'(idx_r + 1'b1);
        end
      end
      S_DEL_SHIFT: begin
        // Move each older entry up by one to close the gap
        wr_en   = 1'b1;
        wr_addr = IW'(idx_r - 1'b1);
        if (idx_last) begin
          count_nxt = count_r - CW'(1);
        end else begin
          rd_en   = 1'b1;
          rd_addr = IW'(idx_r + 1'b1);
          idx_nxt = IW'(idx_r + 1'b1);
        end
      end
      S_INS_SHIFT: begin
        // Move each entry down by one, oldest first
        wr_en   = 1'b1;
        wr_addr = IW'(idx_r + 1'b1);
        if (idx_r != '0) begin
          rd_en   = 1'b1;
          rd_addr = IW'(idx_r - 1'b1);
          idx_nxt = IW'(idx_r - 1'b1);
        end
      end
      S_INS_HEAD: begin
        wr_en         = 1'b1;
        wr_addr       = '0;
        wr_data       = key_r;
        count_nxt     = count_r + CW'(1);
        out_valid_nxt = 1'b1;
        out_nxt       = blank_out;
      end
      S_LIST: begin
        out_valid_nxt           = 1'b1;
        out_nxt.status          = STAT_OK;
        out_nxt.out_bytes_0_7   = rd_data_r.name_low;
        out_nxt.out_bytes_8_15  = rd_data_r.name_mid;
        out_nxt.out_bytes_16_19 = rd_data_r.name_high;
        out_nxt.out_phone       = rd_data_r.phone;
        out_nxt.last_result     = idx_last;
        if (!idx_last) begin
          rd_en   = 1'b1;
          rd_addr = IW'(idx_r + 1'b1);
          idx_nxt = IW'(idx_r + 1'b1);
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    cmd_r <= cmd_nxt;
    key_r <= key_nxt;
    out_r <= out_nxt;
  end

endmodule

[hw/rtl/nket_checker.sv]
// ----------------------------------------------------------------------------
// nket_checker
// Port-level checks on the name keyed entry table.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nket_checker
  import nket_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_item
);

  logic fail_strobe;
  logic fields_blank;

  assign fail_strobe  = out_valid && (out_item.status != STAT_OK);
  assign fields_blank = (out_item.out_phone == '0) &&
                        (out_item.out_bytes_0_7 == '0) &&
                        (out_item.out_bytes_8_15 == '0) &&
                        (out_item.out_bytes_16_19 == '0);

  `ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> (!busy && !out_valid))
  `ASSERT_CLK(a_busy_from_accept, clk, rst_n, $rose(busy) |-> $past(start))
  `ASSERT_CLK(a_stream_continues, clk, rst_n, (out_valid && !out_item.last_result) |=> out_valid)
  `ASSERT_CLK(a_stream_busy, clk, rst_n, (out_valid && !out_item.last_result) |-> busy)
  `ASSERT_CLK(a_fail_blank, clk, rst_n, fail_strobe |-> (out_item.last_result && fields_blank))

endmodule

bind name_keyed_entry_table nket_checker u_nket_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
